>>> src/kghr_pkg.sv
package kghr_pkg;

  localparam int KEY_COUNT_DEF  = 9;
  localparam int PHASE_BITS_DEF = 16;

  localparam int PH_W      = 16;  // internal phase, Q0.16
  localparam int SEG_W     = 4;   // segment index
  localparam int KEY_DEPTH = 16;  // keyframe rom depth
  localparam int POS_W     = 17;  // keyframe position, holds 1.0
  localparam int HUE_W     = 16;  // hue, degrees Q9.7
  localparam int SV_W      = 9;   // saturation / value, Q0.8 with 256 = 1.0
  localparam int RCP_W     = 22;  // span reciprocal
  localparam int W_W       = 17;  // weight, Q0.16 with 65536 = 1.0
  localparam int C_W       = 25;  // channel, Q0.24 with 2^24 = 1.0
  localparam int CH_W      = 8;   // output channel

  localparam logic [W_W-1:0]   W_ONE      = 17'h10000;
  localparam logic [C_W-1:0]   C_ONE      = 25'h1000000;
  localparam logic [HUE_W-1:0] HUE_FULL   = 16'd46080;
  localparam logic [HUE_W-1:0] HUE_SECTOR = 16'd7680;
  // ceil(2^24 / 15): (rem << 16) / 7680 == (rem * F_RECIP) >> 17 over the rem range
  localparam logic [20:0]      F_RECIP    = 21'd1118482;

  typedef logic [POS_W-1:0] pos_rom_t [KEY_DEPTH];
  typedef logic [HUE_W-1:0] hue_rom_t [KEY_DEPTH];
  typedef logic [SV_W-1:0]  sv_rom_t  [KEY_DEPTH];
  typedef logic [RCP_W-1:0] rcp_rom_t [KEY_DEPTH];

  localparam pos_rom_t KEY_POS = '{
    17'd0, 17'd5243, 17'd30802, 17'd32113, 17'd36045, 17'd42598, 17'd49152, 17'd55706,
    17'd65536, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0
  };
  localparam hue_rom_t KEY_HUE = '{
    16'd27776, 16'd43520, 16'd43520, 16'd49664, 16'd27776, 16'd27776, 16'd28672, 16'd27776,
    16'd27776, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0
  };
  localparam sv_rom_t KEY_SAT = '{
    9'd156, 9'd0, 9'd0, 9'd82, 9'd156, 9'd148, 9'd156, 9'd148,
    9'd156, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0
  };
  localparam sv_rom_t KEY_VAL = '{
    9'd141, 9'd256, 9'd256, 9'd256, 9'd141, 9'd154, 9'd205, 9'd154,
    9'd141, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0, 9'd0
  };
  // floor(2^32 / span) for each segment with a positive span
  localparam rcp_rom_t SEG_RECIP = '{
    22'd819181, 22'd168041, 22'd3276100, 22'd1092311,
    22'd655420, 22'd655320, 22'd655320, 22'd436924,
    22'd0, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0, 22'd0
  };

  typedef enum logic [3:0] {
    OP_NONE,
    OP_SEG,
    OP_W,
    OP_MH,
    OP_MS,
    OP_MV,
    OP_F,
    OP_SF,
    OP_SFN,
    OP_Q,
    OP_T,
    OP_P,
    OP_EMIT
  } op_t;

  typedef struct packed {
    logic load;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic out_busy;
  } sts_t;

endpackage

>>> src/keyframe_gradient_hsv_to_rgb_top.sv
// keyframe sky gradient: phase in, interpolated hsv keyframe color out as 8-bit rgb
//
// input channel in_*: one request carries a phase sample, the fraction of one
// period with PHASE_BITS fraction bits; each request yields exactly one result
// output channel out_*: one request carries the red, green and blue bytes
//
// sequencing: the result becomes valid and in_tready rises again in the same
// cycle, so a new request is taken only after the last sample has left its
// emit step; the sequencer walks the single shared multiplier through a
// segment step, ten dependent products and one emit step
//
// reset (rst_n low, synchronous) puts the segment index on the first segment,
// empties the output register and raises in_tready
//
// a stalled receiver: the result waits in the output register while the next
// request is accepted and worked on; that request then waits in its emit step
// until the output register is free
module keyframe_gradient_hsv_to_rgb_top
  import kghr_pkg::*;
#(
  parameter int KEYFRAME_COUNT = KEY_COUNT_DEF,  // keyframes used, 2 to 16
  parameter int PHASE_BITS     = PHASE_BITS_DEF  // phase fraction bits, 8 to 24
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [((PHASE_BITS+7)/8)*8-1:0]  in_tdata,   // phase, zero fill above
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [3*CH_W-1:0]                out_tdata   // red in the low byte, then green, then blue
);

  // command and status between sequencer and datapath
  cmd_t cmd;
  sts_t sts;

  kghr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // upper fill bits of in_tdata are ignored
  kghr_dp #(
    .KEYFRAME_COUNT (KEYFRAME_COUNT),
    .PHASE_BITS     (PHASE_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_data    (in_tdata[PHASE_BITS-1:0]),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

>>> src/kghr_ctrl.sv
module kghr_ctrl
  import kghr_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SEG,
    S_W,
    S_MH,
    S_MS,
    S_MV,
    S_F,
    S_SF,
    S_SFN,
    S_Q,
    S_T,
    S_P,
    S_EMIT
  } state_t;

  state_t state_r;
  op_t    op_r;
  logic   in_tready_r;
  logic   accept;

  assign accept    = in_tvalid && in_tready_r;
  assign in_tready = in_tready_r;
  assign cmd.load  = accept;
  assign cmd.op    = op_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_NONE;
      in_tready_r <= 1'b1;
    end else begin
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r     <= S_SEG;
            op_r        <= OP_SEG;
            in_tready_r <= 1'b0;
          end
        end
        S_SEG: begin
          state_r <= S_W;
          op_r    <= OP_W;
        end
        S_W: begin
          state_r <= S_MH;
          op_r    <= OP_MH;
        end
        S_MH: begin
          state_r <= S_MS;
          op_r    <= OP_MS;
        end
        S_MS: begin
          state_r <= S_MV;
          op_r    <= OP_MV;
        end
        S_MV: begin
          state_r <= S_F;
          op_r    <= OP_F;
        end
        S_F: begin
          state_r <= S_SF;
          op_r    <= OP_SF;
        end
        S_SF: begin
          state_r <= S_SFN;
          op_r    <= OP_SFN;
        end
        S_SFN: begin
          state_r <= S_Q;
          op_r    <= OP_Q;
        end
        S_Q: begin
          state_r <= S_T;
          op_r    <= OP_T;
        end
        S_T: begin
          state_r <= S_P;
          op_r    <= OP_P;
        end
        S_P: begin
          state_r <= S_EMIT;
          op_r    <= OP_EMIT;
        end
        S_EMIT: begin
          // hold until the output register can take the result
          if (!sts.out_busy) begin
            state_r     <= S_IDLE;
            op_r        <= OP_NONE;
            in_tready_r <= 1'b1;
          end
        end
        default: begin
          state_r     <= S_IDLE;
          op_r        <= OP_NONE;
          in_tready_r <= 1'b1;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready_r |-> (state_r == S_IDLE))
    else $error("ready outside idle");
  a_accept_seg: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_SEG) && !in_tready_r)
    else $error("accepted request did not start the sequence");
  a_emit_done: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EMIT) && !sts.out_busy |=> in_tready_r)
    else $error("no return to idle after emit");
`endif

endmodule

>>> src/kghr_dp.sv
module kghr_dp
  import kghr_pkg::*;
#(
  parameter int KEYFRAME_COUNT = KEY_COUNT_DEF,
  parameter int PHASE_BITS     = PHASE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cmd_t                  cmd,
  output sts_t                  sts,
  input  logic [PHASE_BITS-1:0] in_data,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  output logic [3*CH_W-1:0]     out_tdata
);

  localparam logic [SEG_W-1:0] SEG_MAX = SEG_W'(KEYFRAME_COUNT - 2);

  logic [PH_W-1:0]  ph_in;
  logic [PH_W-1:0]  ph_r;
  logic [SEG_W-1:0] seg_r, seg_nxt;
  logic [W_W-1:0]   w_r, w_nxt;
  logic [HUE_W-1:0] h_r;
  logic [SV_W-1:0]  s_r, v_r;
  logic [15:0]      f_r;
  logic [2:0]       sector_r, sector_c;
  logic [C_W-1:0]   sf_r, sfn_r, q24_r, t24_r, p24_r;
  logic             out_tvalid_r;
  logic [CH_W-1:0]  red_r, green_r, blue_r;

  // phase brought to Q0.16
  if (PHASE_BITS >= PH_W) begin : g_ph_dn
    assign ph_in = in_data[PHASE_BITS-1 -: PH_W];
  end else begin : g_ph_up
    assign ph_in = {in_data, {(PH_W-PHASE_BITS){1'b0}}};
  end

  // segment check, one step at most
  logic [SEG_W-1:0] cur0, nxt0, step0;
  logic             outside;
  always_comb begin
    cur0    = (seg_r > SEG_MAX) ? '0 : seg_r;
    nxt0    = cur0 + SEG_W'(1);
    outside = ({1'b0, ph_r} < KEY_POS[cur0]) || ({1'b0, ph_r} > KEY_POS[nxt0]);
    step0   = (cur0 == SEG_MAX) ? '0 : nxt0;
    seg_nxt = outside ? step0 : cur0;
  end

  // keyframes of the current segment
  logic [SEG_W-1:0] seg_n;
  logic [POS_W-1:0] cpos, npos;
  logic             below, zspan;
  logic [PH_W-1:0]  off;
  assign seg_n = seg_r + SEG_W'(1);
  assign cpos  = KEY_POS[seg_r];
  assign npos  = KEY_POS[seg_n];
  assign below = {1'b0, ph_r} < cpos;
  assign zspan = npos == cpos;
  assign off   = PH_W'({1'b0, ph_r} - cpos);

  // mix operands for h, s, v
  logic [HUE_W-1:0]   key_a, key_b;
  logic signed [16:0] key_d;
  always_comb begin
    case (cmd.op)
      OP_MS: begin
        key_a = HUE_W'(KEY_SAT[seg_r]);
        key_b = HUE_W'(KEY_SAT[seg_n]);
      end
      OP_MV: begin
        key_a = HUE_W'(KEY_VAL[seg_r]);
        key_b = HUE_W'(KEY_VAL[seg_n]);
      end
      default: begin
        key_a = KEY_HUE[seg_r];
        key_b = KEY_HUE[seg_n];
      end
    endcase
    key_d = $signed({1'b0, key_b}) - $signed({1'b0, key_a});
  end

  // hue wrap and sector split
  logic [HUE_W-1:0] hw, base_c, thr;
  logic [12:0]      rem_c;
  always_comb begin
    hw       = (h_r >= HUE_FULL) ? h_r - HUE_FULL : h_r;
    sector_c = '0;
    base_c   = '0;
    thr      = '0;
    for (int k = 1; k < 6; k++) begin
      thr = HUE_W'(k * HUE_SECTOR);
      if (hw >= thr) begin
        sector_c = 3'(k);
        base_c   = thr;
      end
    end
    rem_c = 13'(hw - base_c);
  end

  // shared multiplier
  logic signed [25:0] mul_a;
  logic signed [22:0] mul_b;
  logic signed [48:0] mul_p;
  always_comb begin
    case (cmd.op)
      OP_W: begin
        mul_a = $signed(26'(off));
        mul_b = $signed(23'(SEG_RECIP[seg_r]));
      end
      OP_MH, OP_MS, OP_MV: begin
        mul_a = 26'(key_d);
        mul_b = $signed(23'(w_r));
      end
      OP_F: begin
        mul_a = $signed(26'(rem_c));
        mul_b = $signed(23'(F_RECIP));
      end
      OP_SF: begin
        mul_a = $signed(26'(s_r));
        mul_b = $signed(23'(f_r));
      end
      OP_SFN: begin
        mul_a = $signed(26'(s_r));
        mul_b = $signed(23'(W_ONE - {1'b0, f_r}));
      end
      OP_Q: begin
        mul_a = $signed(26'(C_ONE - sf_r));
        mul_b = $signed(23'(v_r));
      end
      OP_T: begin
        mul_a = $signed(26'(C_ONE - sfn_r));
        mul_b = $signed(23'(v_r));
      end
      OP_P: begin
        mul_a = $signed(26'(SV_W'(256) - s_r));
        mul_b = $signed(23'(v_r));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // weight clamp, a + ((b - a) * w >> 16)
  logic [32:0]        w_prod;
  logic signed [33:0] mix_sum;
  assign w_prod  = mul_p[48:16];
  assign mix_sum = $signed({mul_p[48], mul_p[48:16]}) + $signed({18'b0, key_a});
  always_comb begin
    if (below) begin
      w_nxt = '0;
    end else if (zspan) begin
      w_nxt = W_ONE;
    end else if (w_prod > 33'(W_ONE)) begin
      w_nxt = W_ONE;
    end else begin
      w_nxt = w_prod[W_W-1:0];
    end
  end

  // channel select and byte conversion
  function automatic logic [CH_W-1:0] to_byte(input logic [C_W-1:0] c);
    logic [32:0] x;
    x = {c, 8'b0} - {8'b0, c};
    to_byte = x[32] ? '1 : x[31:24];
  endfunction

  logic [C_W-1:0] v24, r24, g24, b24;
  always_comb begin
    v24 = {v_r, 16'b0};
    if (s_r == '0) begin
      r24 = v24; g24 = v24; b24 = v24;
    end else begin
      case (sector_r)
        3'd0:    begin r24 = v24;   g24 = t24_r; b24 = p24_r; end
        3'd1:    begin r24 = q24_r; g24 = v24;   b24 = p24_r; end
        3'd2:    begin r24 = p24_r; g24 = v24;   b24 = t24_r; end
        3'd3:    begin r24 = p24_r; g24 = q24_r; b24 = v24;   end
        3'd4:    begin r24 = t24_r; g24 = p24_r; b24 = v24;   end
        default: begin r24 = v24;   g24 = p24_r; b24 = q24_r; end
      endcase
    end
  end

  logic emit_fire;
  assign sts.out_busy = out_tvalid_r && !out_tready;
  assign emit_fire    = (cmd.op == OP_EMIT) && !sts.out_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seg_r        <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (cmd.op == OP_SEG) begin
        seg_r <= seg_nxt;
      end
      if (emit_fire) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      ph_r <= ph_in;
    end
    case (cmd.op)
      OP_W:   w_r   <= w_nxt;
      OP_MH:  h_r   <= mix_sum[HUE_W-1:0];
      OP_MS:  s_r   <= mix_sum[SV_W-1:0];
      OP_MV:  v_r   <= mix_sum[SV_W-1:0];
      OP_F: begin
        sector_r <= sector_c;
        f_r      <= mul_p[32:17];
      end
      OP_SF:  sf_r  <= mul_p[C_W-1:0];
      OP_SFN: sfn_r <= mul_p[C_W-1:0];
      OP_Q:   q24_r <= mul_p[32:8];
      OP_T:   t24_r <= mul_p[32:8];
      OP_P:   p24_r <= {mul_p[16:0], 8'b0};
      default: begin
      end
    endcase
    if (emit_fire) begin
      red_r   <= to_byte(r24);
      green_r <= to_byte(g24);
      blue_r  <= to_byte(b24);
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {blue_r, green_r, red_r};

`ifndef SYNTHESIS
  a_seg_range: assert property (@(posedge clk) disable iff (!rst_n)
    seg_r <= SEG_MAX)
    else $error("segment index out of range");
  a_w_clamp: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.op == OP_W) |=> (w_r <= W_ONE))
    else $error("weight above one");
  a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    emit_fire |=> out_tvalid_r)
    else $error("emitted result not presented");
`endif

endmodule

>>> dv/tb_keyframe_gradient_hsv_to_rgb_top.sv
// checks keyframe_gradient_hsv_to_rgb_top against a local model of the sky gradient
module tb_keyframe_gradient_hsv_to_rgb_top;
  import kghr_pkg::*;

  localparam int IN_W        = ((PHASE_BITS_DEF + 7) / 8) * 8;
  localparam int CLK_HALF    = 4;
  localparam int TIMEOUT_CYC = 400000;
  localparam int SETTLE_CYC  = 20;     // margin after the last drain, a bit over one sample
  localparam int SHOW_MAX    = 10;

  // keyframe table of the gradient: position Q0.16, hue Q9.7, sat / val Q0.8
  localparam int KF_N = 9;
  localparam longint unsigned KF_POS [KF_N] = '{
    0, 5243, 30802, 32113, 36045, 42598, 49152, 55706, 65536
  };
  localparam longint unsigned KF_HUE [KF_N] = '{
    27776, 43520, 43520, 49664, 27776, 27776, 28672, 27776, 27776
  };
  localparam longint unsigned KF_SAT [KF_N] = '{
    156, 0, 0, 82, 156, 148, 156, 148, 156
  };
  localparam longint unsigned KF_VAL [KF_N] = '{
    141, 256, 256, 256, 141, 154, 205, 154, 141
  };
  localparam longint unsigned Q16_ONE   = 65536;
  localparam longint unsigned HUE_360   = 46080;
  localparam longint unsigned HUE_60    = 7680;

  typedef struct {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } rgb_t;

  logic             clk;
  logic             rst_n;
  logic             in_tvalid;
  logic             in_tready;
  logic [IN_W-1:0]  in_tdata;    // phase
  logic             out_tvalid;
  logic             out_tready;
  logic [3*CH_W-1:0] out_tdata;  // red in the low byte, then green, then blue

  // predicted colors, oldest first
  rgb_t expected_rgb [$];
  // segment the model thinks the block is on
  logic [SEG_W-1:0] seg_cursor;

  int send_idle_pct;
  int recv_idle_pct;
  int recv_hold_len;   // cycles the receiver still refuses, counted by the receiver
  int samples_sent;
  int colors_checked;
  int err_count;

  keyframe_gradient_hsv_to_rgb_top i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_HALF) clk = ~clk;
  end

  // hard stop in case the block hangs
  initial begin
    #(TIMEOUT_CYC * 2 * CLK_HALF);
    $display("timeout after %0d cycles, %0d colors still pending",
             TIMEOUT_CYC, expected_rgb.size());
    $display("DONE: errors detected");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // color model
  // ---------------------------------------------------------------------------

  function automatic longint unsigned lerp_q16(input longint unsigned a,
                                               input longint unsigned b,
                                               input longint unsigned w);
    return (a * (Q16_ONE - w) + b * w) >> 16;
  endfunction

  // Q0.24 channel to a byte, truncating
  function automatic logic [CH_W-1:0] q24_to_byte(input longint unsigned c24);
    longint unsigned r;
    r = (c24 * 255) >> 24;
    if (r > 255) r = 255;
    return r[CH_W-1:0];
  endfunction

  // steps the segment cursor at most once, then blends and converts to rgb
  function automatic rgb_t blend_keyframe_rgb(input logic [IN_W-1:0] phase);
    longint unsigned ph, cur, nxt, span, w, recip, prod;
    longint unsigned h, s, v, sector, rem, f;
    longint unsigned v24, p24, q24, t24, r24, g24, b24;
    rgb_t c;
    ph  = phase[PH_W-1:0];
    cur = seg_cursor;
    if (cur > KF_N - 2) cur = 0;
    nxt = cur + 1;
    if (ph < KF_POS[cur] || ph > KF_POS[nxt]) begin
      cur = cur + 1;
      // stepping onto the last keyframe wraps to the first segment
      if (cur >= KF_N - 1) cur = 0;
      nxt = cur + 1;
    end
    seg_cursor = cur[SEG_W-1:0];

    span = KF_POS[nxt] - KF_POS[cur];
    if (ph < KF_POS[cur]) begin
      w = 0;
    end else if (span == 0) begin
      w = Q16_ONE;
    end else begin
      recip = (64'd1 << 32) / span;
      prod  = ((ph - KF_POS[cur]) * recip) >> 16;
      w     = (prod > Q16_ONE) ? Q16_ONE : prod;
    end

    h = lerp_q16(KF_HUE[cur], KF_HUE[nxt], w);
    s = lerp_q16(KF_SAT[cur], KF_SAT[nxt], w);
    v = lerp_q16(KF_VAL[cur], KF_VAL[nxt], w);

    v24 = v << 16;
    if (s == 0) begin
      r24 = v24;
      g24 = v24;
      b24 = v24;
    end else begin
      if (h >= HUE_360) h = h - HUE_360;
      sector = h / HUE_60;
      rem    = h % HUE_60;
      f      = (rem << 16) / HUE_60;
      p24    = (v * (256 - s)) << 8;
      q24    = (v * ((64'd1 << 24) - s * f)) >> 8;
      t24    = (v * ((64'd1 << 24) - s * (Q16_ONE - f))) >> 8;
      case (sector)
        0: begin r24 = v24; g24 = t24; b24 = p24; end
        1: begin r24 = q24; g24 = v24; b24 = p24; end
        2: begin r24 = p24; g24 = v24; b24 = t24; end
        3: begin r24 = p24; g24 = q24; b24 = v24; end
        4: begin r24 = t24; g24 = p24; b24 = v24; end
        default: begin r24 = v24; g24 = p24; b24 = q24; end
      endcase
    end
    c.red   = q24_to_byte(r24);
    c.green = q24_to_byte(g24);
    c.blue  = q24_to_byte(b24);
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // result side
  // ---------------------------------------------------------------------------

  function automatic void flag_error(input string msg);
    err_count++;
    if (err_count <= SHOW_MAX) $display("error: %s", msg);
  endfunction

  // receiver: random refusals, or a long hold while recv_hold_len runs down
  always @(negedge clk) begin
    if (recv_hold_len > 0) begin
      recv_hold_len = recv_hold_len - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // compares each accepted color with the oldest prediction
  rgb_t want_rgb;
  rgb_t got_rgb;
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_rgb.red   = out_tdata[CH_W-1:0];
      got_rgb.green = out_tdata[2*CH_W-1:CH_W];
      got_rgb.blue  = out_tdata[3*CH_W-1:2*CH_W];
      if (expected_rgb.size() == 0) begin
        flag_error($sformatf("color r=%0d g=%0d b=%0d with no request pending",
                             got_rgb.red, got_rgb.green, got_rgb.blue));
      end else begin
        want_rgb = expected_rgb.pop_front();
        colors_checked++;
        if (got_rgb.red !== want_rgb.red || got_rgb.green !== want_rgb.green ||
            got_rgb.blue !== want_rgb.blue) begin
          flag_error($sformatf("color %0d: expected r=%0d g=%0d b=%0d, got r=%0d g=%0d b=%0d",
                               colors_checked, want_rgb.red, want_rgb.green, want_rgb.blue,
                               got_rgb.red, got_rgb.green, got_rgb.blue));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // request side; tasks enter and leave just after a falling edge
  // ---------------------------------------------------------------------------

  // offers one phase request, with a random gap first, and predicts its color
  task automatic send_phase(input logic [IN_W-1:0] phase);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= phase;
    do @(posedge clk); while (!in_tready);
    expected_rgb.push_back(blend_keyframe_rgb(phase));
    samples_sent++;
    @(negedge clk);
  endtask

  // sender pause: drop valid and wait for every pending color
  task automatic wait_colors_drained();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (expected_rgb.size() != 0) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // both ends of the phase range; also a far jump that clamps the weight at 1
  // and a phase below the new segment start that gives weight 0
  task automatic test_phase_extremes();
    send_phase('0);
    send_phase(16'hFFFF);
    send_phase('0);
  endtask

  // walk the later segments one by one, keyframe edges included, then wrap
  task automatic test_segment_walk();
    send_phase(16'd32113);   // exact end of the current segment, no step
    send_phase(16'd32500);
    send_phase(16'd33500);
    send_phase(16'd35000);
    send_phase(16'd36045);
    send_phase(16'd40000);
    send_phase(16'd45000);
    send_phase(16'd52000);
    send_phase(16'd60000);
    send_phase(16'hFFFF);
    send_phase(16'd100);     // last segment left, cursor back to the first
  endtask

  // grey segment, sector five and hue above 360 that wraps once
  task automatic test_grey_and_hue_wrap();
    send_phase(16'd5243);
    send_phase(16'd5244);    // zero saturation, grey
    send_phase(16'd20000);
    send_phase(16'd30803);
    send_phase(16'd31000);   // hue in sector five
    send_phase(16'd31500);
    send_phase(16'd32000);   // hue past 360 degrees
  endtask

  // mostly rising sweeps with random steps that walk the segments in order,
  // the rest random noise that makes the cursor chase a far phase
  task automatic test_random_mix(input int n, input int s_pct, input int r_pct);
    int sent;
    int run_len;
    int step_max;
    logic [IN_W-1:0] ph;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    sent = 0;
    while (sent < n) begin
      if ($urandom_range(0, 3) == 0) begin
        run_len = $urandom_range(1, 8);
        if (run_len > n - sent) run_len = n - sent;
        repeat (run_len) send_phase(IN_W'($urandom));
      end else begin
        run_len  = $urandom_range(20, 90);
        if (run_len > n - sent) run_len = n - sent;
        step_max = ($urandom_range(0, 4) == 0) ? 4000 : 1200;
        ph       = IN_W'($urandom);
        repeat (run_len) begin
          ph = ph + IN_W'($urandom_range(0, step_max));
          send_phase(ph);
        end
      end
      sent += run_len;
    end
  endtask

  // receiver holds off long enough for the block to fill and drop in_tready
  task automatic test_output_backpressure();
    logic [IN_W-1:0] ph;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    @(posedge clk);
    recv_hold_len = 150;
    @(negedge clk);
    ph = IN_W'($urandom);
    repeat (10) begin
      ph = ph + IN_W'($urandom_range(0, 2000));
      send_phase(ph);
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    in_tvalid     = 1'b0;
    in_tdata      = '0;
    out_tready    = 1'b0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    recv_hold_len = 0;
    samples_sent  = 0;
    colors_checked = 0;
    err_count     = 0;
    seg_cursor    = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_phase_extremes();
    test_segment_walk();
    test_grey_and_hue_wrap();
    wait_colors_drained();

    test_random_mix(430, 29, 47);
    wait_colors_drained();
    test_output_backpressure();
    wait_colors_drained();
    test_random_mix(430, 47, 29);
    wait_colors_drained();
    test_random_mix(430, 0, 0);
    wait_colors_drained();

    repeat (SETTLE_CYC) @(posedge clk);
    if (expected_rgb.size() != 0)
      flag_error($sformatf("%0d colors never arrived", expected_rgb.size()));

    $display("ran %0d phase samples and checked %0d colors: edges, segment walk and wrap,",
             samples_sent, colors_checked);
    $display("grey and hue wrap cases, sweeps with noise, random stalls and a long hold");
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches in total", err_count);
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
